>>> rtl/core/dti_pkg.sv
`timescale 1ns / 1ps
// dti_pkg: shared types, constants and the sine table of the dtmf tone inserter
package dti_pkg;

    // sizes
    localparam int SAMPLE_W         = 16;
    localparam int KEY_W            = 8;
    localparam int RATE_W           = 16;
    localparam int PHASE_W          = 32;
    localparam int FREQ_W           = 11;
    localparam int TONE_TIME_W      = 17;
    localparam int TONE_LEN_W       = 13;
    localparam int MAG_W            = 14;

    localparam int GRANULE_SAMPLES  = 256;
    localparam int GRAN_W           = (GRANULE_SAMPLES > 1) ? $clog2(GRANULE_SAMPLES) : 1;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_QTR         = SINE_TABLE_DEPTH / 4;
    localparam int SINE_QTR_W       = SINE_IDX_W - 2;

    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    // bit-serial divider: frequency followed by PHASE_W zero bits
    localparam int DIVIDEND_W       = FREQ_W + PHASE_W;
    localparam int DIV_CNT_W        = $clog2(DIVIDEND_W + 1);

    // divide by ten as multiply by reciprocal, exact for every 16-bit rate
    localparam int RECIP_SHIFT      = 19;
    localparam logic [RATE_W-1:0] RECIP_TEN = 16'd52429;

    localparam logic [RATE_W-1:0]      RATE_RESET = 16'd8000;
    localparam logic [TONE_TIME_W-1:0] TONE_IDLE  = {TONE_TIME_W{1'b1}};

    // row and column frequencies in hertz
    localparam logic [FREQ_W-1:0] ROW_FREQ [4] = '{11'd697, 11'd770, 11'd852, 11'd941};
    localparam logic [FREQ_W-1:0] COL_FREQ [4] = '{11'd1209, 11'd1336, 11'd1477, 11'd1633};

    // classification of a queued item
    typedef logic [1:0] item_kind_t;
    localparam item_kind_t KIND_SAMPLE = 2'd0;
    localparam item_kind_t KIND_KEY    = 2'd1;
    localparam item_kind_t KIND_REJECT = 2'd2;

    typedef struct packed {
        logic                       req_type;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [KEY_W-1:0]           key_code;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       tone_active;
        logic                       key_rejected;
    } out_item_t;

    typedef struct packed {
        item_kind_t                 kind;
        logic signed [SAMPLE_W-1:0] sample;
        logic [1:0]                 row;
        logic [1:0]                 col;
    } q_entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // magnitude of 10000*sin for quarter-turn step rq, q30 polynomial
    function automatic logic [MAG_W-1:0] sine_mag_calc(input int unsigned rq);
        longint unsigned q30_one;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned m;
        q30_one = 64'h4000_0000;
        r  = longint'(rq) << (30 - SINE_QTR_W);
        x  = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t  = q30_one;
        t  = q30_one - ((x2 * t) >> 30) / 110;
        t  = q30_one - ((x2 * t) >> 30) / 72;
        t  = q30_one - ((x2 * t) >> 30) / 42;
        t  = q30_one - ((x2 * t) >> 30) / 20;
        t  = q30_one - ((x2 * t) >> 30) / 6;
        m  = (((x * t) >> 30) * 64'd10000) >> 30;
        return MAG_W'(m);
    endfunction

    typedef logic [MAG_W-1:0] sine_mag_t [SINE_QTR];

    function automatic sine_mag_t build_sine_mag();
        sine_mag_t tab;
        for (int k = 0; k < SINE_QTR; k++)
        begin
            tab[k] = sine_mag_calc(k);
        end
        return tab;
    endfunction

    localparam sine_mag_t         SINE_MAG  = build_sine_mag();
    localparam logic [MAG_W-1:0]  SINE_PEAK = sine_mag_calc(SINE_QTR);

    // signed table value for a table index, quarter-wave symmetry
    function automatic logic signed [SAMPLE_W-1:0] sine_at(input logic [SINE_IDX_W-1:0] idx);
        logic [1:0]            quad;
        logic [SINE_QTR_W-1:0] r;
        logic [SINE_QTR_W-1:0] mr;
        logic [MAG_W-1:0]      mag;
        logic [SAMPLE_W-1:0]   ext;
        quad = idx[SINE_IDX_W-1 -: 2];
        r    = idx[SINE_QTR_W-1:0];
        mr   = SINE_QTR_W'(0) - r;
        if (quad[0])
        begin
            mag = (r == '0) ? SINE_PEAK : SINE_MAG[mr];
        end
        else
        begin
            mag = SINE_MAG[r];
        end
        ext = SAMPLE_W'(mag);
        return quad[1] ? $signed(-ext) : $signed(ext);
    endfunction

endpackage

>>> rtl/core/dti_front.sv
`timescale 1ns / 1ps
// dti_front: classifies incoming items and decodes key presses
module dti_front
(
    input  dti_pkg::in_item_t item,
    output dti_pkg::q_entry_t entry
);

    logic       valid_key;
    logic [1:0] row;
    logic [1:0] col;

    always_comb
    begin
        valid_key = 1'b1;
        row       = 2'd0;
        col       = 2'd0;
        case (item.key_code)
            "1":     begin row = 2'd0; col = 2'd0; end
            "2":     begin row = 2'd0; col = 2'd1; end
            "3":     begin row = 2'd0; col = 2'd2; end
            "4":     begin row = 2'd1; col = 2'd0; end
            "5":     begin row = 2'd1; col = 2'd1; end
            "6":     begin row = 2'd1; col = 2'd2; end
            "7":     begin row = 2'd2; col = 2'd0; end
            "8":     begin row = 2'd2; col = 2'd1; end
            "9":     begin row = 2'd2; col = 2'd2; end
            "*":     begin row = 2'd3; col = 2'd0; end
            "0":     begin row = 2'd3; col = 2'd1; end
            "#":     begin row = 2'd3; col = 2'd2; end
            "A":     begin row = 2'd0; col = 2'd3; end
            "B":     begin row = 2'd1; col = 2'd3; end
            "C":     begin row = 2'd2; col = 2'd3; end
            "D":     begin row = 2'd3; col = 2'd3; end
            default: valid_key = 1'b0;
        endcase
    end

    always_comb
    begin
        entry.sample = item.sample_in;
        entry.row    = row;
        entry.col    = col;
        if (!item.req_type)
        begin
            entry.kind = dti_pkg::KIND_SAMPLE;
        end
        else if (valid_key)
        begin
            entry.kind = dti_pkg::KIND_KEY;
        end
        else
        begin
            entry.kind = dti_pkg::KIND_REJECT;
        end
    end

endmodule

>>> rtl/core/dti_queue.sv
`timescale 1ns / 1ps
// dti_queue: short register queue between the front and the back
module dti_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  dti_pkg::q_entry_t wr_entry,
    output logic              full,
    output logic              empty,
    input  logic              rd_en,
    output dti_pkg::q_entry_t head
);

    dti_pkg::q_entry_t                mem_reg [dti_pkg::QUEUE_DEPTH];
    logic [dti_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [dti_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [dti_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [dti_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [dti_pkg::QCNT_W-1:0]       count_reg;
    logic [dti_pkg::QCNT_W-1:0]       count_next;
    logic                             do_wr;
    logic                             do_rd;

    localparam logic [dti_pkg::QPTR_W-1:0] PTR_LAST = dti_pkg::QPTR_W'(dti_pkg::QUEUE_DEPTH - 1);
    localparam logic [dti_pkg::QCNT_W-1:0] CNT_FULL = dti_pkg::QCNT_W'(dti_pkg::QUEUE_DEPTH);

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

>>> rtl/core/dti_divider.sv
`timescale 1ns / 1ps
// dti_divider: bit-serial restoring divider for tone phase increments
module dti_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dti_pkg::FREQ_W-1:0]    dividend,
    input  logic [dti_pkg::RATE_W-1:0]    divisor,
    output dti_pkg::div_status_t          stat,
    output logic [dti_pkg::PHASE_W-1:0]   quotient
);

    logic                              busy_reg;
    logic                              busy_next;
    logic                              done_reg;
    logic                              done_next;
    logic [dti_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [dti_pkg::DIV_CNT_W-1:0]     cnt_next;
    logic [dti_pkg::FREQ_W-1:0]        num_reg;
    logic [dti_pkg::FREQ_W-1:0]        num_next;
    logic [dti_pkg::RATE_W-1:0]        div_reg;
    logic [dti_pkg::RATE_W-1:0]        div_next;
    logic [dti_pkg::RATE_W-1:0]        rem_reg;
    logic [dti_pkg::RATE_W-1:0]        rem_next;
    logic [dti_pkg::PHASE_W-1:0]       quo_reg;
    logic [dti_pkg::PHASE_W-1:0]       quo_next;
    logic [dti_pkg::RATE_W:0]          trial;
    logic [dti_pkg::RATE_W:0]          diff;
    logic                              qbit;

    localparam logic [dti_pkg::DIV_CNT_W-1:0] STEPS = dti_pkg::DIV_CNT_W'(dti_pkg::DIVIDEND_W);

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    always_comb
    begin
        // shift the next dividend bit in, subtract where it fits
        trial     = {rem_reg, num_reg[dti_pkg::FREQ_W-1]};
        diff      = trial - {1'b0, div_reg};
        qbit      = (trial >= {1'b0, div_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEPS;
            num_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[dti_pkg::FREQ_W-2:0], 1'b0};
            rem_next = qbit ? diff[dti_pkg::RATE_W-1:0] : trial[dti_pkg::RATE_W-1:0];
            quo_next = {quo_reg[dti_pkg::PHASE_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == dti_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

>>> rtl/core/dti_back.sv
`timescale 1ns / 1ps
// dti_back: tone state, sample replacement, key set-up and result register
module dti_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [dti_pkg::RATE_W-1:0]  cfg_wr_data,
    input  dti_pkg::q_entry_t           head,
    input  logic                        q_empty,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_pop,
    output dti_pkg::out_item_t          out_item
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIV_LO = 2'd1;
    localparam logic [1:0] ST_DIV_HI = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [dti_pkg::TONE_TIME_W-1:0] TONE_LAST = dti_pkg::TONE_IDLE - 1'b1;
    localparam logic [dti_pkg::GRAN_W:0] GRAN_END = (dti_pkg::GRAN_W + 1)'(dti_pkg::GRANULE_SAMPLES);

    logic [1:0]                          state_reg;
    logic [1:0]                          state_next;
    logic [dti_pkg::RATE_W-1:0]          rate_reg;
    logic [dti_pkg::RATE_W-1:0]          rate_next;
    logic [dti_pkg::TONE_TIME_W-1:0]     tone_time_reg;
    logic [dti_pkg::TONE_TIME_W-1:0]     tone_time_next;
    logic [dti_pkg::TONE_LEN_W-1:0]      tone_len_reg;
    logic [dti_pkg::TONE_LEN_W-1:0]      tone_len_next;
    logic [dti_pkg::PHASE_W-1:0]         lo_inc_reg;
    logic [dti_pkg::PHASE_W-1:0]         lo_inc_next;
    logic [dti_pkg::PHASE_W-1:0]         hi_inc_reg;
    logic [dti_pkg::PHASE_W-1:0]         hi_inc_next;
    logic [dti_pkg::PHASE_W-1:0]         lo_phase_reg;
    logic [dti_pkg::PHASE_W-1:0]         lo_phase_next;
    logic [dti_pkg::PHASE_W-1:0]         hi_phase_reg;
    logic [dti_pkg::PHASE_W-1:0]         hi_phase_next;
    logic [dti_pkg::GRAN_W-1:0]          gran_pos_reg;
    logic [dti_pkg::GRAN_W-1:0]          gran_pos_next;
    logic [1:0]                          col_reg;
    logic [1:0]                          col_next;
    logic [dti_pkg::PHASE_W-1:0]         new_lo_reg;
    logic [dti_pkg::PHASE_W-1:0]         new_lo_next;
    logic [dti_pkg::PHASE_W-1:0]         new_hi_reg;
    logic [dti_pkg::PHASE_W-1:0]         new_hi_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    dti_pkg::out_item_t                  out_reg;
    dti_pkg::out_item_t                  out_next;

    logic                                out_ok;
    logic                                out_load;
    logic                                sample_go;
    logic                                gran_wrap;
    logic                                tone_on;
    logic [dti_pkg::TONE_TIME_W-1:0]     tt_step;
    logic [dti_pkg::GRAN_W:0]            gran_inc;
    logic signed [dti_pkg::SAMPLE_W:0]   tone_sum;
    logic [2*dti_pkg::RATE_W-1:0]        len_prod;
    logic [dti_pkg::RATE_W-1:0]          div_rate;

    logic                                div_start;
    logic [dti_pkg::FREQ_W-1:0]          div_dividend;
    dti_pkg::div_status_t                div_stat;
    logic [dti_pkg::PHASE_W-1:0]         div_quot;

    dti_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_rate),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign out_ok    = !out_valid_reg || out_pop;
    assign tone_on   = (tone_time_reg != dti_pkg::TONE_IDLE);
    assign div_rate  = (rate_reg == '0) ? dti_pkg::RATE_W'(1) : rate_reg;
    assign len_prod  = rate_reg * dti_pkg::RECIP_TEN;
    assign tone_sum  = (dti_pkg::SAMPLE_W + 1)'(dti_pkg::sine_at(
                           lo_phase_reg[dti_pkg::PHASE_W-1 -: dti_pkg::SINE_IDX_W]))
                     + (dti_pkg::SAMPLE_W + 1)'(dti_pkg::sine_at(
                           hi_phase_reg[dti_pkg::PHASE_W-1 -: dti_pkg::SINE_IDX_W]));
    assign gran_inc  = {1'b0, gran_pos_reg} + 1'b1;
    assign gran_wrap = (gran_inc >= GRAN_END);
    assign sample_go = (state_reg == ST_IDLE) && !q_empty && out_ok
                     && (head.kind == dti_pkg::KIND_SAMPLE);

    always_comb
    begin
        state_next     = state_reg;
        rate_next      = cfg_wr_en ? cfg_wr_data : rate_reg;
        tone_time_next = tone_time_reg;
        tone_len_next  = tone_len_reg;
        lo_inc_next    = lo_inc_reg;
        hi_inc_next    = hi_inc_reg;
        lo_phase_next  = lo_phase_reg;
        hi_phase_next  = hi_phase_reg;
        gran_pos_next  = gran_pos_reg;
        col_next       = col_reg;
        new_lo_next    = new_lo_reg;
        new_hi_next    = new_hi_reg;
        out_valid_next = out_valid_reg && !out_pop;
        out_next       = out_reg;
        out_load       = 1'b0;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        div_dividend   = dti_pkg::ROW_FREQ[head.row];
        tt_step        = tone_time_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    case (head.kind)
                        dti_pkg::KIND_SAMPLE:
                        begin
                            if (out_ok)
                            begin
                                q_pop    = 1'b1;
                                out_load = 1'b1;
                                if (tone_on)
                                begin
                                    out_next.sample_out = tone_sum[dti_pkg::SAMPLE_W-1:0];
                                    lo_phase_next = lo_phase_reg + lo_inc_reg;
                                    hi_phase_next = hi_phase_reg + hi_inc_reg;
                                    if (tone_time_reg < TONE_LAST)
                                    begin
                                        tt_step = tone_time_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    out_next.sample_out = head.sample;
                                end
                                // end of tone is only checked at a granule boundary
                                if (gran_wrap)
                                begin
                                    gran_pos_next = '0;
                                    if (tt_step != dti_pkg::TONE_IDLE
                                        && tt_step > dti_pkg::TONE_TIME_W'(tone_len_reg))
                                    begin
                                        tt_step = dti_pkg::TONE_IDLE;
                                    end
                                end
                                else
                                begin
                                    gran_pos_next = gran_inc[dti_pkg::GRAN_W-1:0];
                                end
                                tone_time_next        = tt_step;
                                out_next.tone_active  = (tt_step != dti_pkg::TONE_IDLE);
                                out_next.key_rejected = 1'b0;
                            end
                        end
                        dti_pkg::KIND_KEY:
                        begin
                            q_pop        = 1'b1;
                            col_next     = head.col;
                            div_start    = 1'b1;
                            div_dividend = dti_pkg::ROW_FREQ[head.row];
                            state_next   = ST_DIV_LO;
                        end
                        default:
                        begin
                            if (out_ok)
                            begin
                                q_pop                 = 1'b1;
                                out_load              = 1'b1;
                                out_next.sample_out   = '0;
                                out_next.tone_active  = tone_on;
                                out_next.key_rejected = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_DIV_LO:
            begin
                if (div_stat.done)
                begin
                    new_lo_next  = div_quot;
                    div_start    = 1'b1;
                    div_dividend = dti_pkg::COL_FREQ[col_reg];
                    state_next   = ST_DIV_HI;
                end
            end
            ST_DIV_HI:
            begin
                if (div_stat.done)
                begin
                    new_hi_next = div_quot;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_ok)
                begin
                    out_load       = 1'b1;
                    tone_len_next  = len_prod[dti_pkg::RECIP_SHIFT +: dti_pkg::TONE_LEN_W];
                    lo_inc_next    = new_lo_reg;
                    hi_inc_next    = new_hi_reg;
                    lo_phase_next  = '0;
                    hi_phase_next  = '0;
                    tone_time_next = '0;
                    out_next.sample_out   = '0;
                    out_next.tone_active  = 1'b1;
                    out_next.key_rejected = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rate_reg      <= dti_pkg::RATE_RESET;
            tone_time_reg <= dti_pkg::TONE_IDLE;
            tone_len_reg  <= '0;
            lo_inc_reg    <= '0;
            hi_inc_reg    <= '0;
            lo_phase_reg  <= '0;
            hi_phase_reg  <= '0;
            gran_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rate_reg      <= rate_next;
            tone_time_reg <= tone_time_next;
            tone_len_reg  <= tone_len_next;
            lo_inc_reg    <= lo_inc_next;
            hi_inc_reg    <= hi_inc_next;
            lo_phase_reg  <= lo_phase_next;
            hi_phase_reg  <= hi_phase_next;
            gran_pos_reg  <= gran_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg    <= col_next;
        new_lo_reg <= new_lo_next;
        new_hi_reg <= new_hi_next;
        out_reg    <= out_next;
    end

`ifndef NO_ASSERTIONS
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_pop_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("queue popped outside idle");

    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_pop))
        else $error("result register overwritten");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV_LO || state_reg == ST_DIV_HI))
        else $error("divider finished outside a division state");

    a_tone_end_at_granule: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_go && gran_wrap) |=> (tone_time_reg == dti_pkg::TONE_IDLE
            || tone_time_reg <= dti_pkg::TONE_TIME_W'(tone_len_reg)))
        else $error("tone outlived its length at a granule boundary");
`endif

endmodule

>>> rtl/core/dtmf_tone_inserter.sv
`timescale 1ns / 1ps
// dtmf_tone_inserter: top level of the dtmf tone inserter
//
// audio samples pass through unchanged until a key item arrives; a valid
// dtmf key (0-9, *, #, A-D) then replaces the following samples with the
// sum of its row and column sine tones for sample_rate/10 samples, with the
// end only checked once per granule of 256 samples, so a tone can run up to
// one granule longer. unknown keys come back flagged and change nothing.
// every item gives exactly one result item, in order.
// both sides look like a queue: push/full on the input, empty/pop on the
// output. a front decoder classifies each item into a two-entry queue, and
// the back end works through the queue while the finished result sits in
// its own output register.
// timing: samples flow at one per cycle while results are popped. a key item
// runs two divisions of 43 steps each in the bit-serial divider that turns each
// frequency into a phase increment, plus set-up and write-back, and the
// back end takes no other item meanwhile; this divider sets the key rate.
// there is no clearing pass after reset. the user writes sample_rate via
// cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
module dtmf_tone_inserter
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  dti_pkg::in_item_t           push_data,
    output logic                        full,
    output logic                        empty,
    input  logic                        pop,
    output dti_pkg::out_item_t          pop_data,
    input  logic                        cfg_wr_en,
    input  logic [dti_pkg::RATE_W-1:0]  cfg_wr_data
);

    dti_pkg::q_entry_t  fe_entry;
    dti_pkg::q_entry_t  q_head;
    logic               q_empty;
    logic               q_pop;
    logic               out_valid;

    // front: classify samples, decode keys to row and column
    dti_front u_front
    (
        .item  (push_data),
        .entry (fe_entry)
    );

    // short queue so the front keeps accepting while the back is busy
    dti_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_entry (fe_entry),
        .full     (full),
        .empty    (q_empty),
        .rd_en    (q_pop),
        .head     (q_head)
    );

    // back: tone state, division for key set-up, result register
    dti_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_pop     (pop),
        .out_item    (pop_data)
    );

    // result register empty means nothing to pop
    assign empty = !out_valid;

endmodule

>>> bench/dtmf_tone_inserter_tb.sv
`timescale 1ns / 1ps
// dtmf_tone_inserter_tb: self-checking bench for the dtmf tone inserter with its own tone predictor
module dtmf_tone_inserter_tb;

    import dti_pkg::*;

    // bench constants
    localparam logic [TONE_TIME_W-1:0] TONE_OFF = {TONE_TIME_W{1'b1}};
    localparam int GAP_MAX        = 19;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int IDLE_GUARD     = 4;
    localparam int RANDOM_ITEMS   = 1330;
    localparam int PHASE_ITEMS    = 200;
    localparam int MAX_REPORTS    = 60;

    // the sixteen dtmf keys, one ascii byte each
    localparam logic [8*16-1:0] DTMF_KEYS = "0123456789*#ABCD";
    localparam int unsigned ROW_HZ [4] = '{697, 770, 852, 941};
    localparam int unsigned COL_HZ [4] = '{1209, 1336, 1477, 1633};

    // clock, reset and block ports, the driven ones known from time zero
    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              push        = 1'b0;
    in_item_t          push_data   = '0;
    logic              full;
    logic              empty;
    logic              pop         = 1'b0;
    out_item_t         pop_data;
    logic              cfg_wr_en   = 1'b0;
    logic [RATE_W-1:0] cfg_wr_data = '0;

    // predictor copy of the register and the tone state
    logic [RATE_W-1:0]      rate_setting = RATE_W'(8000);
    logic [TONE_TIME_W-1:0] tone_time    = TONE_OFF;
    logic [TONE_LEN_W-1:0]  tone_len     = '0;
    logic [PHASE_W-1:0]     low_step     = '0;
    logic [PHASE_W-1:0]     high_step    = '0;
    logic [PHASE_W-1:0]     low_turn     = '0;
    logic [PHASE_W-1:0]     high_turn    = '0;
    int                     granule_pos  = 0;

    logic signed [SAMPLE_W-1:0] sine_tab [SINE_TABLE_DEPTH];

    // results predicted but not yet seen on the output side
    out_item_t pending_outputs [$];

    // idling knobs for the sender and the receiver
    int send_gap_max    = GAP_MAX;
    int recv_gap_max    = GAP_MAX;
    int pop_hold_cycles = 0;

    int items_sent   = 0;
    int results_seen = 0;
    int error_count  = 0;

    dtmf_tone_inserter i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_data   (push_data),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .pop_data    (pop_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // tone predictor
    // ------------------------------------------------------------------

    // q30 polynomial sine of table step k, scaled to 10000 and truncated
    function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int k);
        longint unsigned q30;
        longint unsigned turn;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned mag;
        int quad;
        logic signed [SAMPLE_W-1:0] val;
        q30  = 64'h4000_0000;
        turn = (longint'(k) << 32) / SINE_TABLE_DEPTH;
        quad = int'(turn >> 30);
        r    = turn & (q30 - 1);
        // mirror the falling quarters back onto the rising one
        if (quad % 2 == 1)
        begin
            r = q30 - r;
        end
        x  = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t  = q30;
        t  = q30 - ((x2 * t) >> 30) / 110;
        t  = q30 - ((x2 * t) >> 30) / 72;
        t  = q30 - ((x2 * t) >> 30) / 42;
        t  = q30 - ((x2 * t) >> 30) / 20;
        t  = q30 - ((x2 * t) >> 30) / 6;
        mag = (((x * t) >> 30) * 64'd10000) >> 30;
        val = SAMPLE_W'(mag);
        // lower half turn is negative
        return (quad >= 2) ? -val : val;
    endfunction

    // row and column frequency of a key, zero when the key is not dtmf
    function automatic bit dtmf_pair(input logic [KEY_W-1:0] key,
                                     output int unsigned lo_hz,
                                     output int unsigned hi_hz);
        int row;
        int col;
        row   = 0;
        col   = 0;
        lo_hz = 0;
        hi_hz = 0;
        if (key >= "1" && key <= "9")
        begin
            row = (key - "1") / 3;
            col = (key - "1") % 3;
        end
        else if (key == "0")
        begin
            row = 3;
            col = 1;
        end
        else if (key == "*")
        begin
            row = 3;
            col = 0;
        end
        else if (key == "#")
        begin
            row = 3;
            col = 2;
        end
        else if (key >= "A" && key <= "D")
        begin
            row = key - "A";
            col = 3;
        end
        else
        begin
            return 1'b0;
        end
        lo_hz = ROW_HZ[row];
        hi_hz = COL_HZ[col];
        return 1'b1;
    endfunction

    // table lookup: top bits of the phase select the entry
    function automatic logic signed [SAMPLE_W-1:0] sine_of_phase(input logic [PHASE_W-1:0] ph);
        return sine_tab[int'((longint'(ph) * SINE_TABLE_DEPTH) >> 32)];
    endfunction

    // works out the result of one accepted item and queues it
    task automatic predict_tone_output(input in_item_t it);
        out_item_t          res;
        int unsigned        lo_hz;
        int unsigned        hi_hz;
        logic [RATE_W-1:0]  divisor;
        logic signed [16:0] sum;
        res = '0;
        if (it.req_type)
        begin
            if (dtmf_pair(it.key_code, lo_hz, hi_hz))
            begin
                // zero rate divides by one, so both steps wrap to zero
                divisor   = (rate_setting == '0) ? RATE_W'(1) : rate_setting;
                tone_len  = TONE_LEN_W'(rate_setting / 10);
                low_step  = PHASE_W'((longint'(lo_hz) << 32) / divisor);
                high_step = PHASE_W'((longint'(hi_hz) << 32) / divisor);
                low_turn  = '0;
                high_turn = '0;
                tone_time = '0;
            end
            else
            begin
                res.key_rejected = 1'b1;
            end
        end
        else
        begin
            if (tone_time != TONE_OFF)
            begin
                sum            = sine_of_phase(low_turn) + sine_of_phase(high_turn);
                res.sample_out = sum[SAMPLE_W-1:0];
                low_turn       = low_turn + low_step;
                high_turn      = high_turn + high_step;
                if (tone_time < TONE_OFF - 1)
                begin
                    tone_time = tone_time + 1'b1;
                end
            end
            else
            begin
                res.sample_out = it.sample_in;
            end
            // the tone may only stop at the close of a granule
            granule_pos++;
            if (granule_pos >= GRANULE_SAMPLES)
            begin
                granule_pos = 0;
                if (tone_time != TONE_OFF && tone_time > tone_len)
                begin
                    tone_time = TONE_OFF;
                end
            end
        end
        res.tone_active = (tone_time != TONE_OFF);
        pending_outputs.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // item builders, the unused field carries random bits
    // ------------------------------------------------------------------

    function automatic in_item_t make_sample(input logic [SAMPLE_W-1:0] s);
        in_item_t it;
        it.req_type  = 1'b0;
        it.sample_in = s;
        it.key_code  = KEY_W'($urandom);
        return it;
    endfunction

    function automatic in_item_t make_key(input logic [KEY_W-1:0] k);
        in_item_t it;
        it.req_type  = 1'b1;
        it.sample_in = SAMPLE_W'($urandom);
        it.key_code  = k;
        return it;
    endfunction

    function automatic logic [KEY_W-1:0] pick_dtmf_key();
        int i;
        i = $urandom_range(0, 15);
        return DTMF_KEYS[8*(15-i) +: 8];
    endfunction

    // any item at all: mostly samples, some keys of any code
    function automatic in_item_t noise_item();
        case ($urandom_range(0, 9))
            0:       return make_key(KEY_W'($urandom));
            1:       return make_key(pick_dtmf_key());
            default: return make_sample(SAMPLE_W'($urandom));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // sender, configuration and idle helpers
    // ------------------------------------------------------------------

    // push stays high on return so that back-to-back items need no toggle
    task automatic send_item(input in_item_t it);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        push_data <= it;
        do @(posedge clk); while (full);
        predict_tone_output(it);
        items_sent++;
    endtask

    // drops push and waits until every predicted result has come back
    task automatic wait_idle(input int guard);
        push <= 1'b0;
        while (pending_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (guard) @(posedge clk);
    endtask

    // register write, only called once the block is idle
    task automatic set_sample_rate(input logic [RATE_W-1:0] rate);
        cfg_wr_data <= rate;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        rate_setting  = rate;
        @(posedge clk);
    endtask

    // key followed by a run of samples, with the odd stray item mixed in
    task automatic send_tone_burst(input int samples);
        send_item(make_key(pick_dtmf_key()));
        for (int n = 0; n < samples; n++)
        begin
            if ($urandom_range(0, 99) < 3)
            begin
                send_item(noise_item());
            end
            else
            begin
                send_item(make_sample(SAMPLE_W'($urandom)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint want, input longint got);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("mismatch at result %0d: %s expected %0d got %0d",
                     results_seen, what, want, got);
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (pending_outputs.size() == 0)
        begin
            report_mismatch("item with nothing pending, sample_out", 0, got.sample_out);
            return;
        end
        want = pending_outputs.pop_front();
        results_seen++;
        if (got.sample_out !== want.sample_out)
        begin
            report_mismatch("sample_out", want.sample_out, got.sample_out);
        end
        if (got.tone_active !== want.tone_active)
        begin
            report_mismatch("tone_active", want.tone_active, got.tone_active);
        end
        if (got.key_rejected !== want.key_rejected)
        begin
            report_mismatch("key_rejected", want.key_rejected, got.key_rejected);
        end
    endtask

    // receiver: random wait per item, plus a long hold when one is requested
    initial
    begin
        int wait_n;
        wait (rst_n);
        forever
        begin
            wait_n          = $urandom_range(0, recv_gap_max) + pop_hold_cycles;
            pop_hold_cycles = 0;
            if (wait_n > 0)
            begin
                pop <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            check_result(pop_data);
        end
    end

    // watchdog: too long with no item moving on either side ends the run
    initial
    begin
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
            begin
                stalled = 0;
            end
            else
            begin
                stalled++;
            end
        end
        $display("dtmf_tone_inserter_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset rate: passthrough extremes, rejected keys, keys mid-granule
    // and a key arriving while a tone is already running
    task automatic test_passthrough_and_keys();
        send_item(make_sample(16'h7FFF));
        send_item(make_sample(16'h8000));
        send_item(make_sample(16'h0000));
        send_item(make_sample(16'hFFFF));
        // codes outside the keypad change nothing
        send_item(make_key(8'h00));
        send_item(make_key(8'hFF));
        send_item(make_key("E"));
        // tone start part way through a granule
        send_item(make_key("5"));
        send_item(make_sample(16'h1234));
        send_item(make_sample(16'h8000));
        send_item(make_sample(16'h0001));
        // restart with a new key during the tone
        send_item(make_key("#"));
        send_item(make_sample(16'h7FFF));
        send_item(make_sample(16'h5A5A));
        send_item(make_key("*"));
        send_item(make_sample(16'hA5A5));
        send_item(make_key("0"));
        send_item(make_sample(16'h0F0F));
        send_item(make_key("D"));
        send_item(make_sample(16'hF0F0));
        // stray code during a tone leaves the tone as it is
        send_item(make_key("x"));
        send_item(make_sample(16'h3C3C));
    endtask

    // zero rate: steps wrap to zero and the tone lasts to the next granule end
    task automatic test_zero_rate_tone();
        wait_idle(IDLE_GUARD);
        set_sample_rate('0);
        send_item(make_key("9"));
        while (tone_time != TONE_OFF)
        begin
            send_item(make_sample(SAMPLE_W'($urandom)));
        end
        repeat (3) send_item(make_sample(SAMPLE_W'($urandom)));
    endtask

    // lowest and highest rates, the longest tone left running across phases
    task automatic test_rate_extremes();
        wait_idle(IDLE_GUARD);
        set_sample_rate(RATE_W'(1));
        send_item(make_key("C"));
        repeat (20) send_item(make_sample(SAMPLE_W'($urandom)));
        wait_idle(IDLE_GUARD);
        set_sample_rate({RATE_W{1'b1}});
        send_item(make_key("3"));
        repeat (30) send_item(make_sample(SAMPLE_W'($urandom)));
        send_item(make_key("A"));
        repeat (10) send_item(make_sample(SAMPLE_W'($urandom)));
    endtask

    // receiver holds off while the sender keeps offering, so full must rise
    task automatic test_input_backpressure();
        wait_idle(IDLE_GUARD);
        set_sample_rate(RATE_W'(8000));
        send_gap_max    = 0;
        pop_hold_cycles = HOLD_CYCLES;
        send_item(make_key("6"));
        repeat (20) send_item(make_sample(SAMPLE_W'($urandom)));
        send_item(make_key("B"));
        repeat (19) send_item(make_sample(SAMPLE_W'($urandom)));
        send_gap_max = GAP_MAX;
    endtask

    // phases of random rate and idling, each a mix of tone bursts and noise
    task automatic test_random_traffic();
        int random_start;
        int phase_start;
        int cap;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            wait_idle(IDLE_GUARD);
            case ($urandom_range(0, 9))
                0:       set_sample_rate('0);
                1:       set_sample_rate(RATE_W'(1));
                2:       set_sample_rate({RATE_W{1'b1}});
                3:       set_sample_rate(RATE_W'(8000));
                default: set_sample_rate(RATE_W'($urandom_range(10, 2560)));
            endcase
            // idling pattern for the whole phase, including none at all
            case ($urandom_range(0, 3))
                0:
                begin
                    send_gap_max = GAP_MAX;
                    recv_gap_max = GAP_MAX;
                end
                1:
                begin
                    send_gap_max = 0;
                    recv_gap_max = 0;
                end
                2:
                begin
                    send_gap_max = 0;
                    recv_gap_max = GAP_MAX;
                end
                default:
                begin
                    send_gap_max = GAP_MAX;
                    recv_gap_max = 0;
                end
            endcase
            // bursts long enough to cross granule ends, capped for high rates
            cap = rate_setting / 10 + 2 * GRANULE_SAMPLES;
            if (cap > 700)
            begin
                cap = 700;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    repeat ($urandom_range(1, 20)) send_item(noise_item());
                    2, 3:    send_tone_burst($urandom_range(0, 8));
                    default: send_tone_burst($urandom_range(0, cap));
                endcase
            end
        end
        send_gap_max = GAP_MAX;
        recv_gap_max = GAP_MAX;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            sine_tab[k] = sine_entry(k);
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough_and_keys();
        test_zero_rate_tone();
        test_rate_extremes();
        test_input_backpressure();
        test_random_traffic();

        // drain, then a margin for anything the block still lets out
        wait_idle(DRAIN_CYCLES);
        if (error_count == 0)
        begin
            $display("dtmf_tone_inserter_tb: PASS");
        end
        else
        begin
            $display("dtmf_tone_inserter_tb: FAIL");
        end
        $finish;
    end

endmodule
